[rtl/tpsf_pkg.sv]
package tpsf_pkg;

	// Configuration register indexes.
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_PHASE_STEP = 2'd0;
	localparam cfg_index_t CFG_AMPLITUDE  = 2'd1;

	localparam int CFG_DATA_W = 32;
	localparam int AMP_W      = 16;
	localparam int SINE_W     = 15;
	localparam int MAG_W      = 31;
	localparam int WORD_W     = 32;
	localparam int QUEUE_DEPTH = 2;

	// Channel codes, one per phase of the output set.
	typedef logic [1:0] chan_t;
	localparam chan_t CH_A = 2'd0;
	localparam chan_t CH_B = 2'd1;
	localparam chan_t CH_C = 2'd2;

	localparam logic [3:0]        LAST_INDEX = 4'd15;
	localparam logic [WORD_W-1:0] TAIL_WORD  = 32'h7F80_0000;
	localparam logic [7:0]        EXP_BIAS_OFFSET = 8'd104;

	typedef enum logic [1:0] {
		CALC_IDLE,
		CALC_ISSUE,
		CALC_WAIT,
		CALC_HOLD
	} calc_state_t;

	typedef logic [2:0][WORD_W-1:0] frame_words_t;

	typedef struct packed {
		logic         valid;
		frame_words_t words;
	} frame_t;

	// Quarter-wave table generation, evaluated at elaboration only.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
			input int unsigned qb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint          sum;
		x = (HALF_PI_Q30 * longint'(i) + (64'd1 << (qb - 1))) >> qb;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 0; n < 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n % 2) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[SINE_W-1:0];
	endfunction

endpackage

[rtl/tpsf_front.sv]
module tpsf_front #(
	parameter int PHASE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           tick,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  tpsf_pkg::cfg_index_t           cfg_index,
	input  logic [tpsf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           q_full,
	output logic                           q_push,
	output logic [PHASE_BITS-1:0]          q_phase,
	output logic [tpsf_pkg::AMP_W-1:0]     amp
);
	import tpsf_pkg::*;

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [AMP_W-1:0]      amp_q;

	// Items with tick low are taken and dropped; only real ticks use a queue slot.
	assign in_ready  = !q_full;
	assign cfg_ready = 1'b1;
	assign q_push    = in_valid && in_ready && tick;
	assign q_phase   = phase_q;
	assign amp       = amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= PHASE_BITS'(32'd42949673);
			amp_q   <= 16'd2304;
		end else begin
			if (cfg_valid && cfg_index == CFG_PHASE_STEP) begin
				step_q <= cfg_data[PHASE_BITS-1:0];
			end
			if (cfg_valid && cfg_index == CFG_AMPLITUDE) begin
				amp_q <= cfg_data[AMP_W-1:0];
			end
			if (q_push) begin
				phase_q <= phase_q + step_q;
			end
		end
	end

endmodule

[rtl/tpsf_queue.sv]
module tpsf_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tpsf_calc.sv]
module tpsf_calc #(
	parameter int TABLE_BITS = 10,
	parameter int PHASE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  logic [PHASE_BITS-1:0]      q_phase,
	output logic                       q_pop,
	input  logic [tpsf_pkg::AMP_W-1:0] amp,
	output tpsf_pkg::frame_t           frame,
	input  logic                       frame_take
);
	import tpsf_pkg::*;

	localparam int QB = TABLE_BITS - 2;
	localparam int Q  = 1 << QB;
	localparam int AW = TABLE_BITS - 1;
	localparam longint unsigned THIRD_L      = ((64'd1 << PHASE_BITS) + 64'd1) / 64'd3;
	localparam longint unsigned TWO_THIRDS_L = ((64'd1 << (PHASE_BITS + 1)) + 64'd1) / 64'd3;
	localparam logic [PHASE_BITS-1:0] THIRD      = THIRD_L[PHASE_BITS-1:0];
	localparam logic [PHASE_BITS-1:0] TWO_THIRDS = TWO_THIRDS_L[PHASE_BITS-1:0];

	// Quarter-wave sine table, Q+1 entries in unsigned Q0.15.
	logic [SINE_W-1:0] sine_rom [Q+1];
	for (genvar gi = 0; gi <= Q; gi++) begin : g_rom
		localparam logic [SINE_W-1:0] ENTRY = sine_entry(unsigned'(gi), QB);
		assign sine_rom[gi] = ENTRY;
	end

	calc_state_t           state_q, state_d;
	chan_t                 ch_q;
	logic [PHASE_BITS-1:0] base_q;
	logic                  issue;
	frame_words_t          words_q;

	logic [PHASE_BITS-1:0] offset;
	logic [PHASE_BITS-1:0] phase;
	logic [TABLE_BITS-1:0] idx;
	logic [QB-1:0]         k;
	logic [AW-1:0]         addr;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	chan_t             ch_s1, ch_s2, ch_s3, ch_s4;
	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SINE_W-1:0] sin_s1;
	logic [MAG_W-1:0]  mag_s2, mag_s3, norm_s4;
	logic [4:0]        e_s3, e_s4;
	logic              zero_s3, zero_s4;

	logic [MAG_W-1:0]  prod;
	logic [4:0]        lead;
	logic [23:0]       mant24;
	logic              round_up;
	logic [24:0]       mant_sum;
	logic [7:0]        exp_f;
	logic [WORD_W-1:0] word;

	// Sequencer: take one phase from the queue, issue three lookups, wait
	// for the words, then hold the frame until the serializer takes it.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			CALC_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = CALC_ISSUE;
				end
			end
			CALC_ISSUE: begin
				issue = 1'b1;
				if (ch_q == CH_C) begin
					state_d = CALC_WAIT;
				end
			end
			CALC_WAIT: begin
				if (vld_s4 && ch_s4 == CH_C) begin
					state_d = CALC_HOLD;
				end
			end
			CALC_HOLD: begin
				if (frame_take) begin
					state_d = CALC_IDLE;
				end
			end
			default: state_d = CALC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CALC_IDLE;
			ch_q    <= CH_A;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				ch_q <= CH_A;
			end else if (issue) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			base_q <= q_phase;
		end
	end

	assign frame.valid = (state_q == CALC_HOLD);
	assign frame.words = words_q;

	// Lookup address: quadrant folds the index onto the quarter table.
	always_comb begin
		unique case (ch_q)
			CH_A:    offset = '0;
			CH_B:    offset = THIRD;
			CH_C:    offset = TWO_THIRDS;
			default: offset = '0;
		endcase
		phase = base_q + offset;
		idx   = phase[PHASE_BITS-1 -: TABLE_BITS];
		k     = idx[QB-1:0];
		addr  = idx[TABLE_BITS-2] ? (AW'(Q) - AW'(k)) : AW'(k);
	end

	assign prod = MAG_W'(sin_s1) * MAG_W'(amp);

	always_comb begin
		lead = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (mag_s2[b]) begin
				lead = 5'(b);
			end
		end
	end

	// Round to nearest even on the normalized magnitude.
	always_comb begin
		mant24   = norm_s4[MAG_W-1:7];
		round_up = norm_s4[6] && ((|norm_s4[5:0]) || mant24[0]);
		mant_sum = {1'b0, mant24} + 25'(round_up);
		exp_f    = {3'b000, e_s4} + EXP_BIAS_OFFSET + {7'd0, mant_sum[24]};
		word     = zero_s4 ? '0 : {neg_s4, exp_f, mant_sum[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sin_s1  <= sine_rom[addr];
		neg_s1  <= idx[TABLE_BITS-1];
		ch_s1   <= ch_q;
		mag_s2  <= prod;
		neg_s2  <= neg_s1;
		ch_s2   <= ch_s1;
		mag_s3  <= mag_s2;
		e_s3    <= lead;
		zero_s3 <= ~|mag_s2;
		neg_s3  <= neg_s2;
		ch_s3   <= ch_s2;
		norm_s4 <= mag_s3 << (5'd30 - e_s3);
		e_s4    <= e_s3;
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
		ch_s4   <= ch_s3;
		if (vld_s4) begin
			words_q[ch_s4] <= word;
		end
	end

endmodule

[rtl/tpsf_ser.sv]
module tpsf_ser (
	input  logic             clk,
	input  logic             arst_n,
	input  tpsf_pkg::frame_t frame,
	output logic             frame_take,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic [3:0]       byte_index,
	output logic             last_byte
);
	import tpsf_pkg::*;

	logic              busy_q;
	logic [3:0]        cnt_q;
	frame_words_t      words_q;
	logic [WORD_W-1:0] cur_word;
	logic              out_fire;

	assign out_fire   = busy_q && out_ready;
	assign frame_take = frame.valid && (!busy_q || (out_ready && cnt_q == LAST_INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (frame_take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (out_fire) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_INDEX) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			words_q <= frame.words;
		end
	end

	always_comb begin
		unique case (cnt_q[3:2])
			2'd0:    cur_word = words_q[0];
			2'd1:    cur_word = words_q[1];
			2'd2:    cur_word = words_q[2];
			default: cur_word = TAIL_WORD;
		endcase
	end

	assign out_valid  = busy_q;
	assign out_byte   = 8'(cur_word >> {cnt_q[1:0], 3'b000});
	assign byte_index = cnt_q;
	assign last_byte  = (cnt_q == LAST_INDEX);

endmodule

[rtl/three_phase_sine_float_framer_unit.sv]
// Three-phase sine generator with a sixteen-byte float frame output. Every
// accepted item with tick high produces one frame: the sines at the current
// phase, plus a third of a turn and plus two thirds of a turn, each scaled by
// the Q8.8 amplitude and sent as an IEEE-754 single, least significant byte
// first, followed by the tail 00 00 80 7F; byte_index numbers the bytes and
// last_byte marks byte 15. The phase then advances by phase_step modulo
// 2^PHASE_BITS. An item with tick low is taken and dropped. Frames go out one
// byte per cycle while out_ready is high, so the sustained rate is set by
// the byte-wide output port; the first byte of a frame follows its item
// through the queue, the lookup pipeline and the serializer. A two-entry
// queue holds pending phases, so inputs keep being taken while a frame is
// still draining. Configuration writes (index 0 phase_step, index 1 amplitude)
// are taken at any time but should be made while no frame is pending.
module three_phase_sine_float_framer_unit #(
	parameter int TABLE_BITS = 10,
	parameter int PHASE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            tick,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  tpsf_pkg::cfg_index_t            cfg_index,
	input  logic [tpsf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic [3:0]                      byte_index,
	output logic                            last_byte
);
	import tpsf_pkg::*;

	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;
	logic [PHASE_BITS-1:0] push_phase;
	logic [PHASE_BITS-1:0] pop_phase;
	logic [AMP_W-1:0]      amp;
	frame_t                frame;
	logic                  frame_take;

	tpsf_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.tick     (tick),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_phase  (push_phase),
		.amp      (amp)
	);

	tpsf_queue #(
		.WIDTH(PHASE_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_phase),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_phase),
		.empty    (q_empty)
	);

	tpsf_calc #(
		.TABLE_BITS(TABLE_BITS),
		.PHASE_BITS(PHASE_BITS)
	) u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_phase   (pop_phase),
		.q_pop     (q_pop),
		.amp       (amp),
		.frame     (frame),
		.frame_take(frame_take)
	);

	tpsf_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.frame_take(frame_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.byte_index(byte_index),
		.last_byte (last_byte)
	);

endmodule

[rtl/tpsf_checker.sv]
module tpsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [3:0] byte_index,
	input logic       last_byte
);

	// A stalled item keeps its place in the frame.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_index) && $stable(out_byte))
		else $error("output item changed while stalled");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_byte == (byte_index == 4'd15)))
		else $error("last_byte does not match byte_index");

	// Within a frame the bytes follow one another with no gap.
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=>
			out_valid && byte_index == $past(byte_index) + 4'd1)
		else $error("frame broken before its last byte");

	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			((byte_index != 4'd12 && byte_index != 4'd13) || out_byte == 8'h00) &&
			(byte_index != 4'd14 || out_byte == 8'h80) &&
			(byte_index != 4'd15 || out_byte == 8'h7F))
		else $error("frame tail is wrong");

endmodule

bind three_phase_sine_float_framer_unit tpsf_checker u_tpsf_checker (.*);
